>>> hdl/sfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_pkg: shared types and constants of the sync frame parser
// Command and status groups between controller and datapath, the CRC step
// function and the configuration register indexes.
// ----------------------------------------------------------------------------
package sfp_pkg;

  // Configuration register indexes.
  localparam logic [7:0] CFG_SYNC_FIRST  = 8'd0;
  localparam logic [7:0] CFG_SYNC_SECOND = 8'd1;

  // Reset values of the sync registers.
  localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND_RST = 8'h55;

  // CRC-16/CCITT-FALSE.
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_TOP  = 16'h8000;

  // Width of the packed result word, whole bytes.
  localparam int unsigned TDATA_W = 40;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic ld_addr;       // accepted byte is the address
    logic ld_cmd;        // accepted byte is the command
    logic ld_len;        // accepted byte is the length
    logic ld_pay;        // accepted byte is a payload byte
    logic ld_crch;       // accepted byte is the CRC high byte
    logic start_replay;  // frame passed the CRC check
    logic replay;        // replaying the stored payload
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic first_hit;    // incoming byte equals sync_first
    logic second_hit;   // incoming byte equals sync_second
    logic len_over;     // incoming length exceeds the payload limit
    logic len_zero;     // incoming length is zero
    logic pay_last;     // incoming payload byte is the final one
    logic crc_ok;       // received CRC matches the running CRC
    logic replay_done;  // final result of the run moves to the output
  } sts_t;

  // One byte of CRC-16, MSB first.
  function automatic logic [15:0] crc16_step(logic [15:0] acc, logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

>>> hdl/sfp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_ctrl: frame parser controller
// Walks the frame fields one accepted byte at a time and sequences replay.
// ----------------------------------------------------------------------------
module sfp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sfp_pkg::sts_t sts_i,
  output sfp_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_SYNC1,
    ST_SYNC2,
    ST_ADDR,
    ST_CMD,
    ST_LEN,
    ST_PAY,
    ST_CRCH,
    ST_CRCL,
    ST_REPLAY
  } state_e;

  state_e state_q;
  logic   rdy_q;
  logic   accept;

  assign accept     = in_valid_i & rdy_q;
  assign in_ready_o = rdy_q;

  always_comb begin
    cmd_o              = '0;
    cmd_o.ld_addr      = accept & (state_q == ST_ADDR);
    cmd_o.ld_cmd       = accept & (state_q == ST_CMD);
    cmd_o.ld_len       = accept & (state_q == ST_LEN);
    cmd_o.ld_pay       = accept & (state_q == ST_PAY);
    cmd_o.ld_crch      = accept & (state_q == ST_CRCH);
    cmd_o.start_replay = accept & (state_q == ST_CRCL) & sts_i.crc_ok;
    cmd_o.replay       = (state_q == ST_REPLAY);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SYNC1;
      rdy_q   <= 1'b1;
    end else begin
      case (state_q)
        ST_SYNC1: begin
          if (accept && sts_i.first_hit) state_q <= ST_SYNC2;
        end
        ST_SYNC2: begin
          if (accept) begin
            if (sts_i.second_hit) begin
              state_q <= ST_ADDR;
            end else if (!sts_i.first_hit) begin
              state_q <= ST_SYNC1;
            end
          end
        end
        ST_ADDR: begin
          if (accept) state_q <= ST_CMD;
        end
        ST_CMD: begin
          if (accept) state_q <= ST_LEN;
        end
        ST_LEN: begin
          if (accept) begin
            if (sts_i.len_over) begin
              state_q <= ST_SYNC1;
            end else if (sts_i.len_zero) begin
              state_q <= ST_CRCH;
            end else begin
              state_q <= ST_PAY;
            end
          end
        end
        ST_PAY: begin
          if (accept && sts_i.pay_last) state_q <= ST_CRCH;
        end
        ST_CRCH: begin
          if (accept) state_q <= ST_CRCL;
        end
        ST_CRCL: begin
          if (accept) begin
            if (sts_i.crc_ok) begin
              state_q <= ST_REPLAY;
              rdy_q   <= 1'b0;
            end else begin
              state_q <= ST_SYNC1;
            end
          end
        end
        ST_REPLAY: begin
          if (sts_i.replay_done) begin
            state_q <= ST_SYNC1;
            rdy_q   <= 1'b1;
          end
        end
        default: begin
          state_q <= ST_SYNC1;
          rdy_q   <= 1'b1;
        end
      endcase
    end
  end

endmodule

>>> hdl/sfp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_datapath: frame parser datapath
// Sync registers, header capture, CRC, payload memory and the result register.
// ----------------------------------------------------------------------------
module sfp_datapath #(
  parameter int unsigned PAYLOAD_CAP = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [7:0]    cfg_index_i,
  input  logic [7:0]    cfg_data_i,
  input  logic [7:0]    rx_byte_i,
  input  sfp_pkg::cmd_t cmd_i,
  output sfp_pkg::sts_t sts_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_addr_o,
  output logic [7:0]    out_cmd_o,
  output logic [5:0]    out_len_o,
  output logic [4:0]    out_index_o,
  output logic [7:0]    out_byte_o,
  output logic          has_byte_o,
  output logic          last_o
);

  localparam int unsigned IDX_W = (PAYLOAD_CAP > 1) ? $clog2(PAYLOAD_CAP) : 1;
  localparam int unsigned LEN_W = $clog2(PAYLOAD_CAP + 1);

  logic [7:0]       sync_first_q, sync_second_q;
  logic [7:0]       hdr_addr_q, hdr_cmd_q, crc_hi_q;
  logic [LEN_W-1:0] hdr_len_q, byte_cnt_q;
  logic [15:0]      crc_q, crc_d;
  logic [7:0]       mem_q [PAYLOAD_CAP];

  logic [LEN_W-1:0] rd_idx_q, rd_pos_q;
  logic [7:0]       rd_data_q;
  logic             rd_pend_q;
  logic             out_valid_q;

  logic             can_load, more, issue, load, load_zero, pend_last;
  logic [LEN_W:0]   cnt_next, pos_next;

  // Status toward the controller.
  assign cnt_next = {1'b0, byte_cnt_q} + 1'b1;
  assign pos_next = {1'b0, rd_pos_q} + 1'b1;
  assign pend_last = (pos_next == {1'b0, hdr_len_q});

  assign can_load  = !out_valid_q || out_ready_i;
  assign more      = (rd_idx_q < hdr_len_q);
  assign load      = cmd_i.replay && rd_pend_q && can_load;
  assign issue     = cmd_i.replay && more && (!rd_pend_q || load);
  assign load_zero = cmd_i.replay && (hdr_len_q == '0) && can_load;

  always_comb begin
    sts_o             = '0;
    sts_o.first_hit   = (rx_byte_i == sync_first_q);
    sts_o.second_hit  = (rx_byte_i == sync_second_q);
    sts_o.len_over    = (rx_byte_i > 8'(PAYLOAD_CAP));
    sts_o.len_zero    = (rx_byte_i == 8'h00);
    sts_o.pay_last    = (cnt_next >= {1'b0, hdr_len_q});
    sts_o.crc_ok      = ({crc_hi_q, rx_byte_i} == crc_q);
    sts_o.replay_done = load_zero || (load && pend_last);
  end

  always_comb begin
    crc_d = crc_q;
    if (cmd_i.ld_addr) begin
      crc_d = sfp_pkg::crc16_step(sfp_pkg::CRC_INIT, rx_byte_i);
    end else if (cmd_i.ld_cmd || cmd_i.ld_len || cmd_i.ld_pay) begin
      crc_d = sfp_pkg::crc16_step(crc_q, rx_byte_i);
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= sfp_pkg::SYNC_FIRST_RST;
      sync_second_q <= sfp_pkg::SYNC_SECOND_RST;
      hdr_len_q     <= '0;
      byte_cnt_q    <= '0;
      rd_idx_q      <= '0;
      rd_pend_q     <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_index_i == sfp_pkg::CFG_SYNC_FIRST)) begin
        sync_first_q <= cfg_data_i;
      end
      if (cfg_we_i && (cfg_index_i == sfp_pkg::CFG_SYNC_SECOND)) begin
        sync_second_q <= cfg_data_i;
      end
      if (cmd_i.ld_len) begin
        hdr_len_q  <= LEN_W'(rx_byte_i);
        byte_cnt_q <= '0;
      end else if (cmd_i.ld_pay) begin
        byte_cnt_q <= cnt_next[LEN_W-1:0];
      end
      if (cmd_i.start_replay) begin
        rd_idx_q  <= '0;
        rd_pend_q <= 1'b0;
      end else begin
        if (issue) rd_idx_q <= rd_idx_q + 1'b1;
        if (issue) begin
          rd_pend_q <= 1'b1;
        end else if (load) begin
          rd_pend_q <= 1'b0;
        end
      end
      if (load || load_zero) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers and memory.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_addr) hdr_addr_q <= rx_byte_i;
    if (cmd_i.ld_cmd) hdr_cmd_q <= rx_byte_i;
    if (cmd_i.ld_crch) crc_hi_q <= rx_byte_i;
    crc_q <= crc_d;
    if (cmd_i.ld_pay) mem_q[byte_cnt_q[IDX_W-1:0]] <= rx_byte_i;
    if (issue) begin
      rd_data_q <= mem_q[rd_idx_q[IDX_W-1:0]];
      rd_pos_q  <= rd_idx_q;
    end
    if (load) begin
      out_addr_o  <= hdr_addr_q;
      out_cmd_o   <= hdr_cmd_q;
      out_len_o   <= 6'(hdr_len_q);
      out_index_o <= 5'(rd_pos_q);
      out_byte_o  <= rd_data_q;
      has_byte_o  <= 1'b1;
      last_o      <= pend_last;
    end else if (load_zero) begin
      out_addr_o  <= hdr_addr_q;
      out_cmd_o   <= hdr_cmd_q;
      out_len_o   <= 6'(hdr_len_q);
      out_index_o <= 5'd0;
      out_byte_o  <= 8'h00;
      has_byte_o  <= 1'b0;
      last_o      <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  // The fill counter never passes the captured length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_cnt_q <= hdr_len_q)
    else $error("payload count beyond frame length");

  // A pending memory read exists only while replaying.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> cmd_i.replay)
    else $error("pending read outside replay");

  // A frame in replay never carries a length above the limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.replay |-> (hdr_len_q <= LEN_W'(PAYLOAD_CAP)))
    else $error("replay of an oversized frame");

  // After the final result of a run is loaded, nothing is left pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_o.replay_done |=> !rd_pend_q)
    else $error("read still pending after the run ended");
`endif

endmodule

>>> hdl/sync_frame_parser_crc16.sv
// Throughput: one received byte per cycle while hunting and capturing a frame.
// A frame passing its CRC holds off input while its results are replayed:
// each payload byte passes from memory through a read register into the
// output register, one result per ready cycle (one result for zero length).
// Reset (rst_ni low, asynchronous) returns to sync hunting and restores the
// sync registers to 0xAA and 0x55; the payload memory is not cleared.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_frame_parser_crc16: byte stream deframer with CRC-16 check
// Hunts for two configurable sync bytes, captures address, command, length
// and payload, checks CRC-16/CCITT-FALSE and replays good frames as results.
// ----------------------------------------------------------------------------
module sync_frame_parser_crc16 #(
  parameter int unsigned PAYLOAD_CAP = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,

  // Configuration write channel. Index 0 is sync_first, index 1 is
  // sync_second; any other index is ignored.
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [7:0]                  cfg_index_i,
  input  logic [7:0]                  cfg_data_i,

  // Received byte stream.
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // [7:0] rx_byte

  // Result stream.
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [7:0] out_addr, [15:8] out_cmd, [21:16] out_len, [26:22] out_index,
  // [34:27] out_byte, [39:35] zero
  output logic [sfp_pkg::TDATA_W-1:0] m_axis_tdata,
  output logic                        m_axis_tuser,   // [0] has_byte
  output logic                        m_axis_tlast    // last result of a frame
);

  sfp_pkg::cmd_t cmd;
  sfp_pkg::sts_t sts;

  logic [7:0] out_addr, out_cmd, out_byte;
  logic [5:0] out_len;
  logic [4:0] out_index;

  // Configuration writes are taken at any time; the user writes them only
  // while the parser is idle.
  assign cfg_ready_o = 1'b1;

  // The controller tracks which frame field the next byte belongs to and
  // holds off the input while a validated frame is replayed.
  sfp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds the sync registers, captured header, running CRC,
  // payload memory and the output register that decouples the result side.
  sfp_datapath #(
    .PAYLOAD_CAP (PAYLOAD_CAP)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .rx_byte_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_addr_o  (out_addr),
    .out_cmd_o   (out_cmd),
    .out_len_o   (out_len),
    .out_index_o (out_index),
    .out_byte_o  (out_byte),
    .has_byte_o  (m_axis_tuser),
    .last_o      (m_axis_tlast)
  );

  // Pack the result fields, lowest field in the lowest bits.
  assign m_axis_tdata = {5'b0, out_byte, out_index, out_len, out_cmd, out_addr};

endmodule
